// ----- rtl/pfdo_pkg.sv -----
// Shared types and constants for the drop-oldest packet buffer.
`timescale 1ns / 1ps

package pfdo_pkg;

   localparam int REQ_W  = 2;
   localparam int LEN_W  = 11;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 2;
   localparam int DROP_W = 8;

   typedef enum logic [REQ_W-1:0] {
      REQ_HEADER = 2'd0,
      REQ_DATA   = 2'd1,
      REQ_READ   = 2'd2
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_REJECT = 2'd2
   } status_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic drop;
      logic finish;
   } pfdo_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_header;
      logic hdr_ok;
      logic need_drop;
      logic can_drop;
      logic rsp_free;
   } pfdo_stat_type;

endpackage

// ----- rtl/pfdo_if.sv -----
// Request and response channel interfaces of the packet buffer.
`timescale 1ns / 1ps

interface pfdo_req_if import pfdo_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [LEN_W-1:0]  pkt_length;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output req_type, output pkt_length, output data_byte,
                   input ready);
   modport sink (input valid, input req_type, input pkt_length, input data_byte,
                 output ready);
endinterface

interface pfdo_rsp_if import pfdo_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [BYTE_W-1:0] read_byte;
   logic              last_of_packet;
   logic [DROP_W-1:0] dropped_packets;

   modport source (output valid, output status, output read_byte, output last_of_packet,
                   output dropped_packets, input ready);
   modport sink (input valid, input status, input read_byte, input last_of_packet,
                 input dropped_packets, output ready);
endinterface

// ----- rtl/pfdo_ctrl.sv -----
// Controller state machine: sequences capture, packet drops and completion of each item.
`timescale 1ns / 1ps

module pfdo_ctrl import pfdo_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  pfdo_stat_type stat,
   output pfdo_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_SETTLE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      do_drop;

   // A header keeps dropping while room is short and something is left to drop.
   assign do_drop = stat.is_header && stat.hdr_ok && stat.need_drop && stat.can_drop;

   always_comb begin
      cmd.capture = 1'b0;
      cmd.drop    = 1'b0;
      cmd.finish  = 1'b0;
      state_in    = state_ff;
      ready_in    = ready_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
               ready_in    = 1'b0;
            end
         end
         S_DECODE: begin
            if (do_drop) begin
               cmd.drop = 1'b1;
               state_in = S_SETTLE;
            end else if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
               ready_in   = 1'b1;
            end
         end
         S_SETTLE: begin
            // The length memory read port is registered and must follow the moved head.
            state_in = S_DECODE;
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// ----- rtl/pfdo_datapath.sv -----
// Datapath: byte and length rings, their pointers and counters, and the response register.
`timescale 1ns / 1ps

module pfdo_datapath import pfdo_pkg::*; #(
   parameter int BYTE_CAPACITY = 1024,
   parameter int LENGTH_SLOTS  = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  pfdo_cmd_type      cmd,
   output pfdo_stat_type     stat,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [LEN_W-1:0]  pkt_length,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [STAT_W-1:0] rsp_status,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic              rsp_last_of_packet,
   output logic [DROP_W-1:0] rsp_dropped_packets
);

   localparam int PW   = $clog2(BYTE_CAPACITY);
   localparam int CW   = $clog2(BYTE_CAPACITY + 1);
   localparam int SW   = PW + 1;
   localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
   localparam int LPW  = $clog2(LENGTH_SLOTS);
   localparam int LCW  = $clog2(LENGTH_SLOTS + 1);

   // Memories
   logic [BYTE_W-1:0] byte_store_ff [BYTE_CAPACITY];
   logic [LEN_W-1:0]  length_store_ff [LENGTH_SLOTS];
   logic [BYTE_W-1:0] byte_rd_ff;
   logic [LEN_W-1:0]  len_rd_ff;
   logic              byte_wr_en, len_wr_en;

   // Control state
   logic [PW-1:0]    byte_head_ff, byte_head_in, byte_tail_ff, byte_tail_in;
   logic [CW-1:0]    byte_count_ff, byte_count_in;
   logic [LPW-1:0]   len_head_ff, len_head_in, len_tail_ff, len_tail_in;
   logic [LCW-1:0]   len_count_ff, len_count_in;
   logic [LEN_W-1:0] write_rem_ff, write_rem_in, read_rem_ff, read_rem_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Captured item and response payload
   logic [REQ_W-1:0]  req_type_ff, req_type_in;
   logic [LEN_W-1:0]  pkt_length_ff, pkt_length_in;
   logic [BYTE_W-1:0] data_byte_ff, data_byte_in;
   logic [DROP_W-1:0] dropped_ff, dropped_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0] read_byte_ff, read_byte_in;
   logic              last_ff, last_in;
   logic [DROP_W-1:0] rsp_dropped_ff, rsp_dropped_in;

   // Decode helpers
   logic [CMPW-1:0]  len_ext, cnt_ext, cap_c, drop_ext, drop_n_ext;
   logic [CW-1:0]    drop_n;
   logic [SW-1:0]    head_sum;
   logic [PW-1:0]    head_after_drop, byte_head_inc, byte_tail_inc;
   logic [LPW-1:0]   len_head_inc, len_tail_inc;
   logic [LEN_W-1:0] drop_len, rr_eff;
   logic             hdr_ok, data_ok, pop, rd_ok;

   assign len_ext = CMPW'(pkt_length_ff);
   assign cnt_ext = CMPW'(byte_count_ff);
   assign cap_c   = CMPW'(BYTE_CAPACITY);

   assign byte_head_inc = (byte_head_ff == PW'(BYTE_CAPACITY - 1)) ? '0 : byte_head_ff + PW'(1);
   assign byte_tail_inc = (byte_tail_ff == PW'(BYTE_CAPACITY - 1)) ? '0 : byte_tail_ff + PW'(1);
   assign len_head_inc  = (len_head_ff == LPW'(LENGTH_SLOTS - 1)) ? '0 : len_head_ff + LPW'(1);
   assign len_tail_inc  = (len_tail_ff == LPW'(LENGTH_SLOTS - 1)) ? '0 : len_tail_ff + LPW'(1);

   assign hdr_ok  = (pkt_length_ff != '0) && (len_ext <= cap_c) && (write_rem_ff == '0);
   assign data_ok = (write_rem_ff != '0) && (cnt_ext < cap_c);

   // The oldest packet is the unread rest of the packet being read, if any,
   // else the packet at the head of the length ring.
   assign drop_len   = (read_rem_ff != '0) ? read_rem_ff : len_rd_ff;
   assign drop_ext   = CMPW'(drop_len);
   assign drop_n_ext = (drop_ext > cnt_ext) ? cnt_ext : drop_ext;
   assign drop_n     = CW'(drop_n_ext);
   assign head_sum   = SW'(byte_head_ff) + SW'(drop_n);
   assign head_after_drop = (head_sum >= SW'(BYTE_CAPACITY)) ?
                            PW'(head_sum - SW'(BYTE_CAPACITY)) : PW'(head_sum);

   // A read opens the next packet when none is in progress.
   assign pop    = (read_rem_ff == '0) && (len_count_ff != '0) && (byte_count_ff != '0);
   assign rr_eff = pop ? len_rd_ff : read_rem_ff;
   assign rd_ok  = (rr_eff != '0) && (byte_count_ff != '0);

   assign stat.is_header = (req_type_ff == REQ_HEADER);
   assign stat.hdr_ok    = hdr_ok;
   assign stat.need_drop = ((cap_c - cnt_ext) < len_ext) ||
                           (len_count_ff >= LCW'(LENGTH_SLOTS - 1));
   assign stat.can_drop  = (read_rem_ff != '0) || (len_count_ff != '0);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign byte_wr_en = cmd.finish && (req_type_ff == REQ_DATA) && data_ok;
   assign len_wr_en  = cmd.finish && (req_type_ff == REQ_HEADER) && hdr_ok;

   always_comb begin
      byte_head_in   = byte_head_ff;
      byte_tail_in   = byte_tail_ff;
      byte_count_in  = byte_count_ff;
      len_head_in    = len_head_ff;
      len_tail_in    = len_tail_ff;
      len_count_in   = len_count_ff;
      write_rem_in   = write_rem_ff;
      read_rem_in    = read_rem_ff;
      req_type_in    = req_type_ff;
      pkt_length_in  = pkt_length_ff;
      data_byte_in   = data_byte_ff;
      dropped_in     = dropped_ff;
      status_in      = status_ff;
      read_byte_in   = read_byte_ff;
      last_in        = last_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.capture) begin
         req_type_in   = req_type;
         pkt_length_in = pkt_length;
         data_byte_in  = data_byte;
         dropped_in    = '0;
      end

      if (cmd.drop) begin
         byte_head_in  = head_after_drop;
         byte_count_in = byte_count_ff - drop_n;
         dropped_in    = dropped_ff + DROP_W'(1);
         if (read_rem_ff != '0) begin
            read_rem_in = '0;
         end else begin
            len_head_in  = len_head_inc;
            len_count_in = len_count_ff - LCW'(1);
         end
      end

      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         status_in      = ST_REJECT;
         read_byte_in   = '0;
         last_in        = 1'b0;
         rsp_dropped_in = '0;
         case (req_type_ff)
            REQ_HEADER: begin
               if (hdr_ok) begin
                  len_tail_in    = len_tail_inc;
                  len_count_in   = len_count_ff + LCW'(1);
                  write_rem_in   = pkt_length_ff;
                  status_in      = ST_OK;
                  rsp_dropped_in = dropped_ff;
               end
            end
            REQ_DATA: begin
               if (data_ok) begin
                  byte_tail_in  = byte_tail_inc;
                  byte_count_in = byte_count_ff + CW'(1);
                  write_rem_in  = write_rem_ff - LEN_W'(1);
                  status_in     = ST_OK;
               end
            end
            REQ_READ: begin
               status_in = ST_EMPTY;
               if (pop) begin
                  len_head_in  = len_head_inc;
                  len_count_in = len_count_ff - LCW'(1);
                  read_rem_in  = rr_eff;
               end
               if (rd_ok) begin
                  byte_head_in  = byte_head_inc;
                  byte_count_in = byte_count_ff - CW'(1);
                  read_rem_in   = rr_eff - LEN_W'(1);
                  read_byte_in  = byte_rd_ff;
                  last_in       = (rr_eff == LEN_W'(1));
                  status_in     = ST_OK;
               end
            end
            default: begin
               status_in = ST_REJECT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_head_ff  <= '0;
         byte_tail_ff  <= '0;
         byte_count_ff <= '0;
         len_head_ff   <= '0;
         len_tail_ff   <= '0;
         len_count_ff  <= '0;
         write_rem_ff  <= '0;
         read_rem_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_head_ff  <= byte_head_in;
         byte_tail_ff  <= byte_tail_in;
         byte_count_ff <= byte_count_in;
         len_head_ff   <= len_head_in;
         len_tail_ff   <= len_tail_in;
         len_count_ff  <= len_count_in;
         write_rem_ff  <= write_rem_in;
         read_rem_ff   <= read_rem_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff    <= req_type_in;
      pkt_length_ff  <= pkt_length_in;
      data_byte_ff   <= data_byte_in;
      dropped_ff     <= dropped_in;
      status_ff      <= status_in;
      read_byte_ff   <= read_byte_in;
      last_ff        <= last_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   // Both rings are read at their heads every cycle; the registered data follows
   // in the cycle after a head or a written entry changes.
   always_ff @(posedge clock) begin
      if (byte_wr_en) begin
         byte_store_ff[byte_tail_ff] <= data_byte_ff;
      end
      byte_rd_ff <= byte_store_ff[byte_head_ff];
   end

   always_ff @(posedge clock) begin
      if (len_wr_en) begin
         length_store_ff[len_tail_ff] <= pkt_length_ff;
      end
      len_rd_ff <= length_store_ff[len_head_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_read_byte       = read_byte_ff;
   assign rsp_last_of_packet  = last_ff;
   assign rsp_dropped_packets = rsp_dropped_ff;

endmodule

// ----- rtl/packet_fifo_drop_oldest.sv -----
// Packet buffer with drop-oldest admission.
//
// The req_ch channel carries one item per handshake: a header that declares a
// packet length, a data byte of the open packet, or a read of the next byte.
// The rsp_ch channel returns exactly one result item per request item, in
// order: a status, the byte read, a last-byte flag and, for a header, how many
// old packets were discarded to make room for it, a partly read one included.
// An item's result reaches the response register when the controller finishes
// it in its decode state, and the request side opens again at that same edge,
// so a new item is only accepted once the last one has left the controller.
// A header goes through a drop and a settle state for each packet it drops,
// because the length ring's registered read port must follow the moved head.
// The response register frees the request side: a new item is accepted while
// a result still waits, and the block only holds when a second result is
// ready while the first has not been taken.
// Reset empties both rings and closes any open write; the byte and length
// memories are not cleared, as an entry is only read after it was written.
// While the receiver stalls, the pending result and its fields stay stable.
`timescale 1ns / 1ps

module packet_fifo_drop_oldest import pfdo_pkg::*; #(
   parameter int BYTE_CAPACITY = 1024,
   parameter int LENGTH_SLOTS  = 128
) (
   input  logic         clock,
   input  logic         reset,
   pfdo_req_if.sink     req_ch,
   pfdo_rsp_if.source   rsp_ch
);

   pfdo_cmd_type  cmd;
   pfdo_stat_type stat;

   pfdo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfdo_datapath #(
      .BYTE_CAPACITY (BYTE_CAPACITY),
      .LENGTH_SLOTS  (LENGTH_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_ch.req_type),
      .pkt_length          (req_ch.pkt_length),
      .data_byte           (req_ch.data_byte),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_status          (rsp_ch.status),
      .rsp_read_byte       (rsp_ch.read_byte),
      .rsp_last_of_packet  (rsp_ch.last_of_packet),
      .rsp_dropped_packets (rsp_ch.dropped_packets)
   );

`ifndef SYNTHESIS
   // The controller issues at most one command in a cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.drop, cmd.finish}))
      else $error("more than one datapath command in a cycle");

   // A completed item always shows up on the response channel.
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_ch.valid)
      else $error("finished item did not reach the response register");

   // Every drop is followed by the settle state before the next decision.
   a_drop_settle: assert property (@(posedge clock) disable iff (reset)
      cmd.drop |=> !cmd.drop && !cmd.finish)
      else $error("drop not followed by a settle cycle");

   // No item is accepted while an earlier one is still in the controller.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ch.ready)
      else $error("request accepted while an item is in progress");
`endif

endmodule

// ----- bench/tb_packet_fifo_drop_oldest.sv -----
// Self-checking bench for the drop-oldest packet buffer with predicted responses.
`timescale 1ns / 1ps

module tb_packet_fifo_drop_oldest;
   import pfdo_pkg::*;

   localparam int BYTE_SLOTS = 1024;
   localparam int LEN_SLOTS  = 128;
   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BYTE_W-1:0] rbyte;
      logic              last;
      logic [DROP_W-1:0] dropped;
   } buffer_rsp_type;

   class packet_ring_checker;
      logic [BYTE_W-1:0] byte_ring[BYTE_SLOTS];
      int                len_ring[LEN_SLOTS];
      int                byte_rd, byte_wr, bytes_held;
      int                len_rd, len_wr, lens_held;
      int                write_left, read_left;
      buffer_rsp_type    pending[$];
      int                errors;

      function void skip_bytes(int n);
         if (n > bytes_held) n = bytes_held;
         byte_rd = (byte_rd + n) % BYTE_SLOTS;
         bytes_held -= n;
      endfunction

      // The unread rest of a partly read packet goes before any queued packet.
      function int drop_oldest_packet();
         if (read_left != 0) begin
            skip_bytes(read_left);
            read_left = 0;
            return 1;
         end
         if (lens_held != 0) begin
            skip_bytes(len_ring[len_rd]);
            len_rd = (len_rd + 1) % LEN_SLOTS;
            lens_held--;
            return 1;
         end
         return 0;
      endfunction

      function void take_request(logic [REQ_W-1:0] kind, logic [LEN_W-1:0] length,
                                 logic [BYTE_W-1:0] payload);
         buffer_rsp_type r;
         int n;
         int dropped;
         n = int'(length);
         dropped = 0;
         r = '0;
         r.status = ST_REJECT;
         if (kind == REQ_HEADER) begin
            if (n != 0 && n <= BYTE_SLOTS && write_left == 0) begin
               while (BYTE_SLOTS - bytes_held < n) begin
                  if (drop_oldest_packet() == 0) break;
                  dropped++;
               end
               while (lens_held + 1 >= LEN_SLOTS) begin
                  if (drop_oldest_packet() == 0) break;
                  dropped++;
               end
               len_ring[len_wr] = n;
               len_wr = (len_wr + 1) % LEN_SLOTS;
               lens_held++;
               write_left = n;
               r.status = ST_OK;
            end
         end else if (kind == REQ_DATA) begin
            if (write_left != 0 && bytes_held < BYTE_SLOTS) begin
               byte_ring[byte_wr] = payload;
               byte_wr = (byte_wr + 1) % BYTE_SLOTS;
               bytes_held++;
               write_left--;
               r.status = ST_OK;
            end
         end else if (kind == REQ_READ) begin
            r.status = ST_EMPTY;
            // A new packet is only opened for reading once some byte is stored.
            if (read_left == 0 && lens_held != 0 && bytes_held != 0) begin
               read_left = len_ring[len_rd];
               len_rd = (len_rd + 1) % LEN_SLOTS;
               lens_held--;
            end
            if (read_left != 0 && bytes_held != 0) begin
               r.rbyte = byte_ring[byte_rd];
               byte_rd = (byte_rd + 1) % BYTE_SLOTS;
               bytes_held--;
               read_left--;
               r.last = (read_left == 0);
               r.status = ST_OK;
            end
         end
         r.dropped = DROP_W'(dropped);
         pending.push_back(r);
      endfunction

      function void compare_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_response(buffer_rsp_type got);
         buffer_rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected, status %0d byte %0d", $time,
                     got.status, got.rbyte);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("status", LEN_W'(want.status), LEN_W'(got.status));
         compare_field("read_byte", LEN_W'(want.rbyte), LEN_W'(got.rbyte));
         compare_field("last_of_packet", LEN_W'(want.last), LEN_W'(got.last));
         compare_field("dropped_packets", LEN_W'(want.dropped), LEN_W'(got.dropped));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic rsp_take = 1'b0;
   int   sent = 0;
   int   gap_odds = 0;
   int   stall_odds = 0;
   int   stall_left = 0;
   bit   quiet = 1'b0;

   packet_ring_checker chk = new();

   pfdo_req_if req_if ();
   pfdo_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_take;

   packet_fifo_drop_oldest u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check each accepted item, then decide whether to stall.
   always @(posedge clock) begin
      buffer_rsp_type seen;
      if (!reset && rsp_if.valid && rsp_take) begin
         seen.status  = rsp_if.status;
         seen.rbyte   = rsp_if.read_byte;
         seen.last    = rsp_if.last_of_packet;
         seen.dropped = rsp_if.dropped_packets;
         chk.match_response(seen);
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_take <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
         stall_left = $urandom_range(14, 0);
         rsp_take <= 1'b0;
      end else begin
         rsp_take <= 1'b1;
      end
   end

   function automatic logic [LEN_W-1:0] any_len();
      return LEN_W'($urandom);
   endfunction

   function automatic logic [BYTE_W-1:0] any_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic int small_len();
      if ($urandom_range(9, 0) == 0) return $urandom_range(48, 9);
      return $urandom_range(8, 1);
   endfunction

   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] length,
                            input logic [BYTE_W-1:0] payload);
      int gap;
      // Every few dozen items the idling rates change; zero turns idling off.
      if (!quiet && sent % 48 == 0) begin
         gap_odds = 4 * $urandom_range(3, 0);
         stall_odds = 4 * $urandom_range(3, 0);
      end
      if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
         gap = $urandom_range(15, 1);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= kind;
      req_if.pkt_length <= length;
      req_if.data_byte <= payload;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      chk.take_request(kind, length, payload);
      sent++;
   endtask

   task automatic send_read();
      send_item(REQ_READ, any_len(), any_byte());
   endtask

   task automatic send_noise();
      case ($urandom_range(4, 0))
         0: send_item(REQ_UNKNOWN, any_len(), any_byte());
         1: send_item(REQ_HEADER, '0, any_byte());
         2: send_item(REQ_HEADER, LEN_W'($urandom_range(2047, BYTE_SLOTS + 1)), any_byte());
         3: send_item(REQ_DATA, any_len(), any_byte());
         default: send_item(REQ_HEADER, LEN_W'($urandom_range(64, 1)), any_byte());
      endcase
   endtask

   // Declares a packet and fills whatever write is open, with reads mixed in.
   task automatic send_packet(input int n, input int read_pct, input bit noisy);
      send_item(REQ_HEADER, LEN_W'(n), any_byte());
      while (chk.write_left != 0) begin
         if ($urandom_range(99, 0) < read_pct) send_read();
         else if (noisy && $urandom_range(9, 0) == 0) send_noise();
         else send_item(REQ_DATA, any_len(), any_byte());
      end
   endtask

   initial begin
      int r;
      int n;
      int k;
      int ring_hits;
      int cap_hits;
      req_if.valid <= 1'b0;
      req_if.req_type <= REQ_READ;
      req_if.pkt_length <= '0;
      req_if.data_byte <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_read();
      send_item(REQ_DATA, any_len(), 8'h3C);
      send_item(REQ_HEADER, '0, any_byte());
      send_item(REQ_HEADER, LEN_W'(BYTE_SLOTS + 1), any_byte());
      send_item(REQ_HEADER, '1, any_byte());
      send_item(REQ_UNKNOWN, any_len(), any_byte());
      send_item(REQ_HEADER, LEN_W'(1), any_byte());
      send_item(REQ_HEADER, LEN_W'(5), any_byte());
      send_item(REQ_DATA, any_len(), 8'hFF);
      send_read();
      send_read();
      send_item(REQ_HEADER, LEN_W'(3), any_byte());
      send_item(REQ_DATA, any_len(), 8'h00);
      send_read();
      // The next byte of the head packet has not arrived yet.
      send_read();
      send_item(REQ_DATA, any_len(), 8'hA5);
      send_item(REQ_DATA, any_len(), 8'h5A);
      send_item(REQ_DATA, any_len(), 8'h77);
      send_read();
      send_read();
      send_read();

      while (sent < 150) begin
         r = $urandom_range(99, 0);
         if (r < 45) send_packet(small_len(), 25, 1'b1);
         else if (r < 85) repeat ($urandom_range(6, 1)) send_read();
         else send_noise();
      end

      // Tiny packets, almost no reads, until the length ring overflows a few times.
      ring_hits = 0;
      while (ring_hits < 4) begin
         if (chk.lens_held >= LEN_SLOTS - 1) ring_hits++;
         if ($urandom_range(19, 0) == 0) send_noise();
         else send_packet($urandom_range(4, 1), 2, 1'b0);
      end

      // Medium packets until the byte ring has to make room.
      cap_hits = 0;
      while (cap_hits < 2) begin
         n = $urandom_range(96, 16);
         if (n > BYTE_SLOTS - chk.bytes_held) cap_hits++;
         send_packet(n, 3, 1'b0);
      end

      quiet = 1'b1;
      gap_odds = 0;
      stall_odds = 0;
      k = 0;
      while (chk.read_left == 0 && k < 40) begin
         send_read();
         k++;
      end
      // A full-size packet throws out the partly read one and everything queued.
      send_item(REQ_HEADER, LEN_W'(BYTE_SLOTS), any_byte());
      repeat (40) begin
         if ($urandom_range(2, 0) == 0) send_read();
         else send_item(REQ_DATA, any_len(), any_byte());
      end
      req_if.valid <= 1'b0;

      while (chk.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (chk.errors == 0) begin
         $display("packet_fifo_drop_oldest test passed");
      end else begin
         $display("packet_fifo_drop_oldest test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("packet_fifo_drop_oldest test failed");
      $finish;
   end

endmodule
